/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the multiply/divide unit, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, with reset masking the check.
`define ASSERT_CLKRST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, also while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/q16md_pkg.sv */
// Package of types and constants for the Q16.16 multiply/divide unit.
`timescale 1ns / 1ps

package q16md_pkg;

	localparam int WORD_W        = 32;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [0:0] {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DIV0 = 2'd1,
		STAT_OVF  = 2'd2
	} stat_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_FIN
	} fsm_state_t;

	typedef struct packed {
		op_e                      cmd;
		logic signed [WORD_W-1:0] operand_a;
		logic signed [WORD_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		stat_e                    status;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic step;
		logic wr_out;
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

/* rtl/q16md_ctrl.sv */
// Controller state machine of the multiply/divide unit.
`timescale 1ns / 1ps

module q16md_ctrl #(
	parameter int FRAC_BITS = q16md_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  q16md_pkg::op_e     req_cmd,
	output logic               req_ready,
	input  q16md_pkg::dp_sts_t sts,
	output q16md_pkg::ctl_t    ctl
);

	localparam int DIV_STEPS = q16md_pkg::WORD_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	q16md_pkg::fsm_state_t state_q, state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic                  accept;
	logic                  last_step;

	assign accept    = req_valid && req_ready;
	assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			q16md_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = (req_cmd == q16md_pkg::OP_DIV) ? q16md_pkg::S_DIV
					                                         : q16md_pkg::S_FIN;
				end
			end
			q16md_pkg::S_DIV: begin
				if (last_step) state_d = q16md_pkg::S_FIN;
			end
			q16md_pkg::S_FIN: begin
				if (!sts.out_busy) state_d = q16md_pkg::S_IDLE;
			end
			default: state_d = q16md_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		ctl        = '0;
		unique case (state_q)
			q16md_pkg::S_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = req_valid;
			end
			q16md_pkg::S_DIV: ctl.step   = 1'b1;
			q16md_pkg::S_FIN: ctl.wr_out = !sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= q16md_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= '0;
			else if (ctl.step) cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

/* rtl/q16md_dpath.sv */
// Datapath of the multiply/divide unit: multiplier, radix-2 divider, output register.
`timescale 1ns / 1ps

module q16md_dpath #(
	parameter int FRAC_BITS = q16md_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q16md_pkg::req_t    req,
	input  q16md_pkg::ctl_t    ctl,
	output q16md_pkg::dp_sts_t sts,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output q16md_pkg::rsp_t    rsp
);

	localparam int W  = q16md_pkg::WORD_W;
	localparam int QW = W + FRAC_BITS;

	logic signed [2*W-1:0] prod_q;
	logic signed [2*W-1:0] prod_sh;
	q16md_pkg::op_e        op_q;
	logic                  neg_q;
	logic [W-1:0]          mb_q;
	logic [QW-1:0]         quo_q;
	logic [W-1:0]          rem_q;
	logic [W:0]            rem_sh;
	logic                  q_bit;
	logic [W-1:0]          ma;
	logic [W-1:0]          mb;
	q16md_pkg::rsp_t       fin;
	q16md_pkg::rsp_t       rsp_q;
	logic                  rsp_valid_q;
	logic                  ovf_pos;
	logic                  ovf_neg;
	logic [2*W-1:W-1]      hi;

	// Magnitudes; the most negative value maps to 2^31 as unsigned.
	assign ma = req.operand_a[W-1] ? W'(-req.operand_a) : W'(req.operand_a);
	assign mb = req.operand_b[W-1] ? W'(-req.operand_b) : W'(req.operand_b);

	// For a nonzero divisor the remainder stays below it, so it fits in W bits.
	assign rem_sh = {rem_q, quo_q[QW-1]};
	assign q_bit  = (rem_sh >= {1'b0, mb_q});

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prod_q <= (2*W)'($signed(req.operand_a) * $signed(req.operand_b));
			op_q   <= req.cmd;
			neg_q  <= req.operand_a[W-1] ^ req.operand_b[W-1];
			mb_q   <= mb;
			quo_q  <= {ma, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
		end else if (ctl.step) begin
			rem_q <= q_bit ? W'(rem_sh - {1'b0, mb_q}) : rem_sh[W-1:0];
			quo_q <= {quo_q[QW-2:0], q_bit};
		end
	end

	assign prod_sh = prod_q >>> FRAC_BITS;
	assign hi      = prod_sh[2*W-1:W-1];
	assign ovf_pos = |quo_q[QW-1:W-1];
	assign ovf_neg = (|quo_q[QW-1:W]) | (quo_q[W-1] & (|quo_q[W-2:0]));

	always_comb begin
		fin = '0;
		case (op_q)
			q16md_pkg::OP_MUL: begin
				fin.result_value = prod_sh[W-1:0];
				fin.status       = ((&hi) || !(|hi)) ? q16md_pkg::STAT_OK
				                                     : q16md_pkg::STAT_OVF;
			end
			default: begin
				if (mb_q == '0) begin
					fin.result_value = '0;
					fin.status       = q16md_pkg::STAT_DIV0;
				end else begin
					fin.result_value = neg_q ? W'(-quo_q[W-1:0]) : quo_q[W-1:0];
					fin.status       = (neg_q ? ovf_neg : ovf_pos) ? q16md_pkg::STAT_OVF
					                                               : q16md_pkg::STAT_OK;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_out) rsp_q <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.wr_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

/* rtl/q16_16_mul_div_unit.sv */
// Top level of the signed Q16.16 multiply/divide unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Signed fixed-point multiply and divide, one result item per request item.
// A multiply registers the 32x32 product at acceptance; in S_FIN the product
// is shifted, checked and written to the output register once that register
// is free. A divide runs the restoring radix-2 divider in S_DIV, which retires
// one quotient bit per cycle over the 32 + FRAC_BITS bit dividend, and then
// writes the result in S_FIN the same way.
// One item is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register, even while that result still
// waits for rsp_ready. Status reports divide by zero (result 0) and overflow
// (low 32 bits of the exact result returned). There is no memory and no
// clearing pass after reset.
module q16_16_mul_div_unit #(
	parameter int FRAC_BITS = q16md_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  q16md_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output q16md_pkg::rsp_t rsp
);

	q16md_pkg::ctl_t    ctl;
	q16md_pkg::dp_sts_t sts;

	// Sequence load, divide steps and the write of the output register.
	q16md_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_cmd  (req.cmd),
		.req_ready(req_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Hold operands, run the multiplier and divider, drive the result item.
	q16md_dpath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// After an accepted item the controller must leave idle.
	`ASSERT_CLKRST(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready, "ready after accept")
	// Never overwrite a result that is still waiting to be taken.
	`ASSERT_CLKRST(a_no_overwrite, ctl.wr_out |-> !sts.out_busy, "output register overwritten")
	// A divide step never coincides with loading a new item.
	`ASSERT_CLK(a_step_not_load, !(ctl.step && ctl.load), "step during load")

endmodule
